FILE: hw/rtl/sts_pkg.sv
`default_nettype none

package sts_pkg;

   localparam int KEY_W      = 48;
   localparam int HIGH_W     = 56;
   localparam int LOW_W      = 64;
   localparam int INDEX_W    = 16;
   localparam int COUNT_W    = 17;

   localparam logic FUNC_WRITE  = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   typedef struct packed {
      logic               func;
      logic [INDEX_W-1:0] entry_index;
      logic [KEY_W-1:0]   record_key;
      logic [HIGH_W-1:0]  text_high;
      logic [LOW_W-1:0]   text_low;
   } req_type;

   typedef struct packed {
      logic              found;
      logic [HIGH_W-1:0] result_high;
      logic [LOW_W-1:0]  result_low;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [HIGH_W-1:0] high;
      logic [LOW_W-1:0]  low;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP_LO,
      ST_CMP_HI,
      ST_CMP_MID
   } ctl_state_type;

   typedef enum logic [1:0] {
      RD_ZERO,
      RD_LO,
      RD_HI,
      RD_MID_OR_NEXT
   } rd_sel_type;

   typedef struct packed {
      logic       write;
      logic       load;
      rd_sel_type rd_sel;
      logic       step;
      logic       finish;
      logic       hit;
   } ctl_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic key_eq;
      logic mid_is_lo;
      logic mid_gt;
      logic bounds_meet;
   } ctl_sts_type;

endpackage

`default_nettype wire

FILE: hw/rtl/sts_ctl.sv
`default_nettype none

module sts_ctl
   import sts_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        req_func,
   output      logic        busy,
   input  wire ctl_sts_type sts,
   output      ctl_cmd_type cmd
);

   ctl_state_type state_ff;
   ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.rd_sel = RD_LO;
      busy       = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_func == FUNC_WRITE) begin
                  cmd.write = 1'b1;
               end else begin
                  cmd.load   = 1'b1;
                  cmd.rd_sel = RD_ZERO;
                  if (sts.count_zero) begin
                     cmd.finish = 1'b1;
                  end else begin
                     state_in = ST_CMP_LO;
                  end
               end
            end
         end
         ST_CMP_LO: begin
            if (sts.key_eq) begin
               cmd.finish = 1'b1;
               cmd.hit    = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               cmd.rd_sel = RD_HI;
               state_in   = ST_CMP_HI;
            end
         end
         ST_CMP_HI: begin
            if (sts.key_eq) begin
               cmd.finish = 1'b1;
               cmd.hit    = 1'b1;
               state_in   = ST_IDLE;
            end else if (sts.mid_is_lo) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               cmd.rd_sel = RD_MID_OR_NEXT;
               state_in   = ST_CMP_MID;
            end
         end
         ST_CMP_MID: begin
            // narrow the bounds and fetch the new start key in the same cycle
            cmd.step   = 1'b1;
            cmd.rd_sel = RD_MID_OR_NEXT;
            if (sts.bounds_meet) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               state_in = ST_CMP_LO;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_busy_ends_with_finish: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> $past(cmd.finish))
      else $error("search ended without a response");

   a_hit_needs_match: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && cmd.hit) |-> sts.key_eq)
      else $error("hit reported without a key match");

   a_write_no_response: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func == FUNC_WRITE) |-> (!cmd.finish && !cmd.load))
      else $error("write request started a lookup");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/sts_dp.sv
`default_nettype none

module sts_dp
   import sts_pkg::*;
#(
   parameter int TABLE_DEPTH = 65536
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire req_type            req_data,
   input  wire logic               csr_valid,
   input  wire logic [COUNT_W-1:0] csr_data,
   input  wire ctl_cmd_type        cmd,
   output      ctl_sts_type        sts,
   output      logic               rsp_valid,
   output      rsp_type            rsp_data
);

   localparam int AW = $clog2(TABLE_DEPTH);

   entry_type          mem [TABLE_DEPTH];
   entry_type          rd_data_ff;

   logic [COUNT_W-1:0] count_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [AW-1:0]      lo_ff;
   logic [AW-1:0]      hi_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic [31:0]        live_count;
   logic [AW:0]        mid_sum;
   logic [AW-1:0]      mid;
   logic [AW-1:0]      rd_addr;
   logic               wr_en;

   assign live_count = (32'(count_ff) > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : 32'(count_ff);
   assign mid_sum    = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid        = mid_sum[AW:1];
   assign wr_en      = cmd.write && (32'(req_data.entry_index) < 32'(TABLE_DEPTH));

   assign sts.count_zero  = (count_ff == '0);
   assign sts.key_eq      = (rd_data_ff.key == key_ff);
   assign sts.mid_is_lo   = (mid == lo_ff);
   assign sts.mid_gt      = (rd_data_ff.key > key_ff);
   assign sts.bounds_meet = sts.mid_gt ? (lo_ff == mid) : (mid == hi_ff);

   always_comb begin
      case (cmd.rd_sel)
         RD_ZERO:        rd_addr = '0;
         RD_LO:          rd_addr = lo_ff;
         RD_HI:          rd_addr = hi_ff;
         // midpoint before the step, new start bound during the step
         RD_MID_OR_NEXT: rd_addr = (cmd.step && sts.mid_gt) ? lo_ff : mid;
         default:        rd_addr = lo_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[AW'(req_data.entry_index)] <= '{key:  req_data.record_key,
                                             high: req_data.text_high,
                                             low:  req_data.text_low};
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_valid) begin
         count_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff <= req_data.record_key;
         lo_ff  <= '0;
         hi_ff  <= AW'(live_count - 32'd1);
      end else if (cmd.step) begin
         if (sts.mid_gt) begin
            hi_ff <= mid;
         end else begin
            lo_ff <= mid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.finish;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         if (cmd.hit) begin
            rsp_ff <= '{found: 1'b1, result_high: rd_data_ff.high, result_low: rd_data_ff.low};
         end else begin
            rsp_ff <= '0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_bounds_ordered: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (lo_ff < hi_ff))
      else $error("search bounds crossed");

   a_miss_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.found) |-> (rsp_ff.result_high == '0 && rsp_ff.result_low == '0))
      else $error("miss carries a nonzero value");

   a_write_alone: assert property (@(posedge clock) disable iff (reset)
      cmd.write |-> !(cmd.load || cmd.step || cmd.finish))
      else $error("table write overlaps a lookup");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/sorted_table_binary_search.sv
// Sorted key table with binary-search lookup.
//
// Request channel: present req_data and raise start; the request is taken at
// a clock edge where start is high and busy is low. func = write stores one
// entry (key and 15-byte value) at entry_index and gives no response; busy
// stays low, so a new request may follow in the next cycle. func = lookup
// searches the first min(entry_count, TABLE_DEPTH) entries and gives one response.
// Response channel: rsp_valid is high for exactly one cycle with rsp_data;
// the receiver cannot stall it, so it must take the response when shown.
// Configuration: csr_data written when csr_valid is high (csr_ready is always
// high) sets entry_count; write it only while no lookup is in flight.
// Search: each halving step reads the start key, the end key and the midpoint
// key in turn from the single-port table and compares each with the request
// key; the search ends with a last start and end compare. An empty table
// answers a miss in the cycle after accept.
// Reset: clears the control state and entry_count; table contents are not
// cleared, and an entry must be written before a lookup can reach it.

`default_nettype none

module sorted_table_binary_search
   import sts_pkg::*;
#(
   parameter int TABLE_DEPTH = 65536
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output      logic               busy,
   input  wire req_type            req_data,
   output      logic               rsp_valid,
   output      rsp_type            rsp_data,
   input  wire logic               csr_valid,
   output      logic               csr_ready,
   input  wire logic [COUNT_W-1:0] csr_data
);

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   assign csr_ready = 1'b1;

   sts_ctl u_ctl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_data.func),
      .busy     (busy),
      .sts      (sts),
      .cmd      (cmd)
   );

   sts_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

FILE: dv/search_checker.sv
`timescale 1ns / 100ps

module search_checker
   import sts_pkg::*;
#(
   parameter int TABLE_DEPTH = 65536
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  req_type            req_data,
   input  logic               rsp_valid,
   input  rsp_type            rsp_data,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [COUNT_W-1:0] csr_data,
   output int                 pending_count,
   output int                 fail_count
);

   logic [KEY_W-1:0]  key_mem  [0:TABLE_DEPTH-1];
   logic [HIGH_W-1:0] high_mem [0:TABLE_DEPTH-1];
   logic [LOW_W-1:0]  low_mem  [0:TABLE_DEPTH-1];
   logic [COUNT_W-1:0] live_count;
   rsp_type            predicted_rsp_q [$];
   rsp_type            oldest;

   function automatic rsp_type hit_at(input int unsigned slot);
      rsp_type answer;
      answer.found       = 1'b1;
      answer.result_high = high_mem[slot];
      answer.result_low  = low_mem[slot];
      return answer;
   endfunction

   function automatic rsp_type search_table(input logic [KEY_W-1:0] key);
      rsp_type     miss;
      int unsigned n;
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      miss = '0;
      n = (live_count > TABLE_DEPTH) ? TABLE_DEPTH : live_count;
      if (n == 0) return miss;
      lo = 0;
      hi = n - 1;
      do begin
         if (key_mem[lo] == key) return hit_at(lo);
         if (key_mem[hi] == key) return hit_at(hi);
         mid = (lo + hi) / 2;
         if (mid == lo) return miss;
         // narrow toward the half that can still hold the key
         if (key_mem[mid] > key) hi = mid;
         else lo = mid;
      end while (lo != hi);
      return miss;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         live_count = '0;
         predicted_rsp_q.delete();
      end else begin
         if (rsp_valid) begin
            if (predicted_rsp_q.size() == 0) begin
               $error("response with no request waiting: found %0h high %0h low %0h",
                      rsp_data.found, rsp_data.result_high, rsp_data.result_low);
               fail_count++;
            end else begin
               oldest = predicted_rsp_q.pop_front();
               if (rsp_data.found !== oldest.found) begin
                  $error("found: expected %0h, actual %0h", oldest.found, rsp_data.found);
                  fail_count++;
               end
               if (rsp_data.result_high !== oldest.result_high) begin
                  $error("result_high: expected %0h, actual %0h",
                         oldest.result_high, rsp_data.result_high);
                  fail_count++;
               end
               if (rsp_data.result_low !== oldest.result_low) begin
                  $error("result_low: expected %0h, actual %0h",
                         oldest.result_low, rsp_data.result_low);
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready) live_count = csr_data;
         if (start && !busy) begin
            if (req_data.func == FUNC_WRITE) begin
               if (req_data.entry_index < TABLE_DEPTH) begin
                  key_mem[req_data.entry_index]  = req_data.record_key;
                  high_mem[req_data.entry_index] = req_data.text_high;
                  low_mem[req_data.entry_index]  = req_data.text_low;
               end
            end else begin
               predicted_rsp_q.push_back(search_table(req_data.record_key));
            end
         end
      end
      // publish after the edge so the stimulus never sees a half-updated count
      pending_count <= predicted_rsp_q.size();
   end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import sts_pkg::*;

   localparam int DEPTH       = 65536;
   localparam int SETTLE      = 60;
   localparam int QUIET_LIMIT = 5000;

   logic               clock;
   logic               reset     = 1'b1;
   logic               start     = 1'b0;
   logic               busy;
   req_type            req_data  = '0;
   logic               rsp_valid;
   rsp_type            rsp_data;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [COUNT_W-1:0] csr_data  = '0;

   int pending_count;
   int fail_count;
   int quiet_cycles = 0;
   int burst_left   = 0;
   int live_n       = 0;

   logic [KEY_W-1:0] loaded_key [0:DEPTH-1];

   sorted_table_binary_search #(
      .TABLE_DEPTH (DEPTH)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   search_checker #(
      .TABLE_DEPTH (DEPTH)
   ) checker_inst (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .pending_count (pending_count),
      .fail_count    (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("sorted_table_binary_search verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic issue(input req_type item);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
   endtask

   task automatic put_entry(input logic [INDEX_W-1:0] slot, input logic [KEY_W-1:0] key,
                            input logic [HIGH_W-1:0] high, input logic [LOW_W-1:0] low);
      req_type item;
      item.func        = FUNC_WRITE;
      item.entry_index = slot;
      item.record_key  = key;
      item.text_high   = high;
      item.text_low    = low;
      loaded_key[slot] = key;
      issue(item);
   endtask

   task automatic find_key(input logic [KEY_W-1:0] key);
      req_type item;
      item.func        = FUNC_LOOKUP;
      item.entry_index = INDEX_W'($urandom);
      item.record_key  = key;
      item.text_high   = HIGH_W'({$urandom, $urandom});
      item.text_low    = {$urandom, $urandom};
      issue(item);
   endtask

   // hold off new requests until every response is back
   task automatic wait_empty();
      start <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic set_count(input logic [COUNT_W-1:0] value);
      wait_empty();
      repeat (SETTLE) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      live_n = (value > DEPTH) ? DEPTH : value;
   endtask

   task automatic load_sorted(input int n);
      logic [KEY_W-1:0] key;
      key = ($urandom_range(0, 3) == 0) ? '0 : KEY_W'($urandom);
      for (int i = 0; i < n; i++) begin
         put_entry(INDEX_W'(i), key, HIGH_W'({$urandom, $urandom}), {$urandom, $urandom});
         // repeat a key now and then
         if ($urandom_range(0, 9) != 0) key = key + 1 + $urandom_range(0, 1 << 24);
      end
   endtask

   task automatic random_item();
      int pick;
      int slot;
      pick = $urandom_range(0, 99);
      slot = (live_n > 0) ? $urandom_range(0, live_n - 1) : 0;
      if (pick < 30) begin
         if (live_n > 0 && pick < 15) begin
            // refresh a live entry, keeping its key most of the time
            put_entry(INDEX_W'(slot),
                      ($urandom_range(0, 3) == 0) ? KEY_W'({$urandom, $urandom})
                                                  : loaded_key[slot],
                      HIGH_W'({$urandom, $urandom}), {$urandom, $urandom});
         end else begin
            put_entry(INDEX_W'($urandom), KEY_W'({$urandom, $urandom}),
                      HIGH_W'({$urandom, $urandom}), {$urandom, $urandom});
         end
      end else if (live_n > 0 && pick < 75) begin
         find_key(loaded_key[slot]);
      end else if (live_n > 0 && pick < 85) begin
         find_key(($urandom_range(0, 1) == 0) ? loaded_key[slot] + 1 : loaded_key[slot] - 1);
      end else if (pick < 95) begin
         find_key(KEY_W'({$urandom, $urandom}));
      end else begin
         find_key(($urandom_range(0, 1) == 0) ? '0 : '1);
      end
      if ($urandom_range(0, 39) == 0) wait_empty();
   endtask

   task automatic run_phase(input logic [COUNT_W-1:0] count, input int items,
                            input bit reload);
      if (reload) load_sorted((count > DEPTH) ? DEPTH : count);
      set_count(count);
      repeat (items) random_item();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table after reset
      find_key('0);
      find_key('1);
      put_entry(0, '0, '1, '1);
      put_entry(1, 48'h414243444546, 56'h4e4f5254482053, 64'h4f55544820574553);
      put_entry(2, '1, '0, '0);
      put_entry('1, '1, '1, '1);
      set_count(1);
      find_key('0);
      find_key(48'h414243444546);
      set_count(2);
      find_key(48'h414243444546);
      find_key(48'h000000000001);
      set_count(3);
      find_key('0);
      find_key(48'h414243444546);
      find_key('1);
      find_key(48'h414243444545);
      find_key(48'hfffffffffffe);

      run_phase(1, 50, 1'b1);
      run_phase(2, 50, 1'b1);
      run_phase(3, 50, 1'b1);
      run_phase(COUNT_W'($urandom_range(4, 40)), 90, 1'b1);
      run_phase(COUNT_W'($urandom_range(4, 40)), 90, 1'b1);
      run_phase(COUNT_W'($urandom_range(100, 1000)), 100, 1'b1);
      // count above the table depth, full table
      run_phase('1, 90, 1'b1);
      run_phase(COUNT_W'(DEPTH), 40, 1'b0);
      run_phase(COUNT_W'(DEPTH - 1), 40, 1'b0);
      run_phase(0, 30, 1'b0);

      wait_empty();
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("sorted_table_binary_search verification clean");
      end else begin
         $display("sorted_table_binary_search verification failed");
      end
      $finish;
   end

endmodule
